[src/assert_macros.svh]
// Assertion macros used by the soft limiter sequencer.
// Stand-alone header; the including file supplies clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define TSL_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition must hold in the cycle after the trigger.
`define TSL_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/tsl_pkg.sv]
// Package for the tanh soft limiter: fixed-point constants, tanh table,
// controller state and command/status types. No dependencies.
package tsl_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int PCM_W     = 16;
    localparam int FRAC_BITS = 22;
    localparam int KNEE_Q16  = 55706;
    localparam int DEPTH     = 64;

    localparam longint unsigned ONE   = 64'd1 << FRAC_BITS;
    localparam longint unsigned TS    = (64'(KNEE_Q16) << FRAC_BITS) >> 16;
    localparam longint unsigned SPAN  = ONE - TS;
    localparam longint unsigned SAT_D = SPAN << 3;

    localparam int SPAN_W   = $clog2(SPAN + 1);
    localparam int SEG_BITS = 19;
    localparam int U_W      = 19;
    localparam int DIV_K    = U_W + SPAN_W;
    localparam longint unsigned DIV_M = (64'd1 << DIV_K) / SPAN;
    localparam int DIV_M_W  = $clog2(DIV_M + 1);
    localparam int DIV_SH   = DIV_K - 16;

    localparam int TAB_W  = 31;
    localparam int Y_W    = 31;
    localparam int IDX_W  = $clog2(DEPTH + 1);
    localparam int SEG_W  = $clog2(DEPTH);
    localparam longint unsigned Q30_ONE  = 64'd1 << 30;
    localparam longint unsigned Q30_HALF = 64'd1 << 29;

    // Step of 2z between table points, 16/DEPTH in Q30.
    localparam longint unsigned TANH_X = (64'd16 << 30) / DEPTH;

    localparam int PCM_SCALE    = 32767;
    localparam int PCM_POS_MAX  = 32767;
    localparam int PCM_NEG_MAG  = 32768;

    typedef logic [TAB_W-1:0] tanh_tab_t [0:DEPTH];

    // Exact truncating quotient of two elaboration-time constants, by shift and
    // subtract. The divisor stays below 2^63.
    function automatic longint unsigned const_div(longint unsigned num,
                                                  longint unsigned den);
        longint unsigned q;
        longint unsigned rm;
        int              i;
        q  = '0;
        rm = '0;
        for (i = 63; i >= 0; i--)
        begin
            rm = {rm[62:0], num[i]};
            if (rm >= den)
            begin
                rm   = rm - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Table of tanh at DEPTH+1 evenly spaced points over [0, 8], Q30.
    // tanh(z) = (1 - e^-2z) / (1 + e^-2z), with e^-2z built from a per-step
    // factor raised by square-and-multiply.
    function automatic tanh_tab_t build_tanh_table();
        tanh_tab_t       t;
        longint unsigned x;
        longint unsigned e;
        longint unsigned term;
        longint unsigned n;
        longint unsigned d;
        longint unsigned r;
        longint unsigned base;
        longint unsigned kk;
        int              k;
        int              b;
        x    = TANH_X;
        e    = Q30_ONE;
        term = Q30_ONE;
        for (n = 1; n < 40 && term != 0; n++)
        begin
            term = const_div((term * x) >> 30, n);
            e    = e + term;
        end
        d = const_div((64'd1 << 60) + (e >> 1), e);
        for (k = 0; k <= DEPTH; k++)
        begin
            r    = Q30_ONE;
            base = d;
            kk   = 64'(k);
            for (b = 0; b < 11; b++)
            begin
                if (kk[0])
                begin
                    r = (r * base + Q30_HALF) >> 30;
                end
                base = (base * base + Q30_HALF) >> 30;
                kk   = kk >> 1;
            end
            t[k] = TAB_W'(const_div(((Q30_ONE - r) << 30) + ((Q30_ONE + r) >> 1),
                                    Q30_ONE + r));
        end
        return t;
    endfunction

    localparam tanh_tab_t TANH_TABLE = build_tanh_table();

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_MUL,
        ST_DIV_BACK,
        ST_DIV_FIX,
        ST_INTERP_MUL,
        ST_INTERP_ADD,
        ST_SCALE_MUL,
        ST_PCM_MUL,
        ST_LOAD
    } tsl_state_t;

    typedef struct packed {
        logic capture;
        logic div_mul;
        logic div_back;
        logic div_fix;
        logic interp_mul;
        logic interp_add;
        logic scale_mul;
        logic pcm_mul;
        logic load;
    } tsl_cmd_t;

    typedef struct packed {
        logic in_limited;
        logic out_busy;
    } tsl_status_t;

endpackage

[src/tsl_ctrl.sv]
// Sequencer for the soft limiter: steps one sample through the datapath.
// Depends on tsl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tsl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  tsl_pkg::tsl_status_t status,
    output tsl_pkg::tsl_cmd_t    cmd
);

    tsl_pkg::tsl_state_t state_reg;
    tsl_pkg::tsl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        sample_ready = 1'b0;
        unique case (state_reg)
            tsl_pkg::ST_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.capture = 1'b1;
                    // Samples at or below the knee skip the tanh path.
                    state_next  = status.in_limited ? tsl_pkg::ST_DIV_MUL
                                                    : tsl_pkg::ST_PCM_MUL;
                end
            end
            tsl_pkg::ST_DIV_MUL:
            begin
                cmd.div_mul = 1'b1;
                state_next  = tsl_pkg::ST_DIV_BACK;
            end
            tsl_pkg::ST_DIV_BACK:
            begin
                cmd.div_back = 1'b1;
                state_next   = tsl_pkg::ST_DIV_FIX;
            end
            tsl_pkg::ST_DIV_FIX:
            begin
                cmd.div_fix = 1'b1;
                state_next  = tsl_pkg::ST_INTERP_MUL;
            end
            tsl_pkg::ST_INTERP_MUL:
            begin
                cmd.interp_mul = 1'b1;
                state_next     = tsl_pkg::ST_INTERP_ADD;
            end
            tsl_pkg::ST_INTERP_ADD:
            begin
                cmd.interp_add = 1'b1;
                state_next     = tsl_pkg::ST_SCALE_MUL;
            end
            tsl_pkg::ST_SCALE_MUL:
            begin
                cmd.scale_mul = 1'b1;
                state_next    = tsl_pkg::ST_PCM_MUL;
            end
            tsl_pkg::ST_PCM_MUL:
            begin
                cmd.pcm_mul = 1'b1;
                state_next  = tsl_pkg::ST_LOAD;
            end
            tsl_pkg::ST_LOAD:
            begin
                // Hold until the output register is free or being emptied.
                if (!status.out_busy)
                begin
                    cmd.load   = 1'b1;
                    state_next = tsl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tsl_pkg::ST_IDLE;
            end
        endcase
    end

    `TSL_ASSERT_NEXT(a_one_item, clk, rst_n, sample_valid && sample_ready, !sample_ready, "second sample taken while one is in flight")
    `TSL_ASSERT_NOW(a_load_free, clk, rst_n, cmd.load, !status.out_busy, "result loaded over an untaken result")
    `TSL_ASSERT_NOW(a_cmd_onehot, clk, rst_n, 1'b1, $onehot0({cmd.capture, cmd.div_mul, cmd.div_back, cmd.div_fix, cmd.interp_mul, cmd.interp_add, cmd.scale_mul, cmd.pcm_mul, cmd.load}), "more than one datapath step at once")

endmodule

[src/tsl_datapath.sv]
// Datapath of the soft limiter: knee test, constant division, tanh table
// interpolation, PCM scaling and rounding, take statistics, output register.
// Depends on tsl_pkg.
module tsl_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tsl_pkg::tsl_cmd_t                  cmd,
    output tsl_pkg::tsl_status_t               status,
    input  logic signed [tsl_pkg::SAMPLE_W-1:0] sample,
    input  logic                               last_of_take,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic signed [tsl_pkg::PCM_W-1:0]    pcm,
    output logic                               limited_now,
    output logic [tsl_pkg::SAMPLE_W-1:0]        peak_so_far,
    output logic                               limited_so_far,
    output logic                               take_done
);

    localparam int MAG_W   = tsl_pkg::SAMPLE_W;
    localparam int X_W     = MAG_W + 16;
    localparam int P1_W    = MAG_W + tsl_pkg::DIV_M_W;
    localparam int POS_W   = tsl_pkg::U_W + tsl_pkg::SEG_W;
    localparam int IP_W    = tsl_pkg::TAB_W + tsl_pkg::SEG_BITS;
    localparam int S_W     = tsl_pkg::SPAN_W + tsl_pkg::Y_W;
    localparam int PROD_W  = MAG_W + 15;
    localparam int Q_W     = PROD_W - tsl_pkg::FRAC_BITS;
    localparam int QR_W    = Q_W + 1;

    // Capture of the input sample.
    logic                              neg_in;
    logic [MAG_W-1:0]                  mag_in;
    logic [MAG_W-1:0]                  d_in;
    logic                              neg_reg;
    logic [MAG_W-1:0]                  mag_reg;
    logic [MAG_W-1:0]                  d_reg;
    logic                              sat_reg;
    logic                              limited_reg;
    logic                              last_reg;

    // Division of the overshoot by the span, by reciprocal and correction.
    logic [P1_W-1:0]                   p1_reg;
    logic [tsl_pkg::U_W-1:0]           q0_reg;
    logic [X_W-1:0]                    qd_reg;
    logic [X_W-1:0]                    rem_x;
    logic [tsl_pkg::U_W-1:0]           u_reg;

    // Table interpolation.
    logic [POS_W-1:0]                  pos;
    logic [tsl_pkg::SEG_BITS-1:0]      frac;
    logic [tsl_pkg::IDX_W-1:0]         idx_a;
    logic [tsl_pkg::IDX_W-1:0]         idx_b;
    logic [tsl_pkg::TAB_W-1:0]         ta;
    logic [tsl_pkg::TAB_W-1:0]         tb;
    logic [tsl_pkg::TAB_W-1:0]         dabs;
    logic [tsl_pkg::TAB_W-1:0]         a_reg;
    logic                              up_reg;
    logic [IP_W-1:0]                   iprod_reg;
    logic [IP_W:0]                     iround;
    logic [tsl_pkg::TAB_W-1:0]         adj;
    logic [tsl_pkg::Y_W-1:0]           y_reg;
    logic [S_W-1:0]                    s_reg;
    logic [S_W:0]                      srnd;

    // PCM scaling and rounding.
    logic [MAG_W-1:0]                  outmag;
    logic [PROD_W-1:0]                 pprod_reg;
    logic [Q_W-1:0]                    q_trunc;
    logic [tsl_pkg::FRAC_BITS-1:0]     q_rem;
    logic                              q_inc;
    logic [QR_W-1:0]                   q_rnd;
    logic [QR_W-1:0]                   q_clamp;
    logic [tsl_pkg::PCM_W-1:0]         pcm_val;

    // Take statistics and output register.
    logic [MAG_W-1:0]                  peak_reg;
    logic                              engaged_reg;
    logic [MAG_W-1:0]                  peak_now;
    logic                              engaged_now;
    logic                              result_valid_reg;
    logic signed [tsl_pkg::PCM_W-1:0]  pcm_reg;
    logic                              limited_now_reg;
    logic [MAG_W-1:0]                  peak_out_reg;
    logic                              engaged_out_reg;
    logic                              take_done_reg;

    assign neg_in = sample[MAG_W-1];
    // Two's complement negation in the same width; the most negative input
    // yields 2^23, which fits as unsigned.
    assign mag_in = neg_in ? (~sample + 1'b1) : sample;
    assign d_in   = mag_in - MAG_W'(tsl_pkg::TS);

    assign status.in_limited = (64'(mag_in) > tsl_pkg::TS);
    assign status.out_busy   = result_valid_reg && !result_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            neg_reg     <= neg_in;
            mag_reg     <= mag_in;
            d_reg       <= d_in;
            sat_reg     <= (64'(d_in) >= tsl_pkg::SAT_D);
            limited_reg <= status.in_limited;
            last_reg    <= last_of_take;
        end
    end

    // Quotient estimate is low by at most one; the remainder check fixes it.
    always_ff @(posedge clk)
    begin
        if (cmd.div_mul)
        begin
            p1_reg <= P1_W'(d_reg) * P1_W'(tsl_pkg::DIV_M);
        end
        if (cmd.div_back)
        begin
            q0_reg <= p1_reg[tsl_pkg::DIV_SH +: tsl_pkg::U_W];
            qd_reg <= X_W'(p1_reg[tsl_pkg::DIV_SH +: tsl_pkg::U_W]) * X_W'(tsl_pkg::SPAN);
        end
        if (cmd.div_fix)
        begin
            u_reg <= (rem_x >= X_W'(tsl_pkg::SPAN)) ? q0_reg + 1'b1 : q0_reg;
        end
    end

    assign rem_x = {d_reg, 16'd0} - qd_reg;

    assign pos   = POS_W'(u_reg) * POS_W'(tsl_pkg::DEPTH);
    assign frac  = pos[tsl_pkg::SEG_BITS-1:0];
    assign idx_a = tsl_pkg::IDX_W'(pos[POS_W-1:tsl_pkg::SEG_BITS]);
    assign idx_b = idx_a + 1'b1;
    assign ta    = tsl_pkg::TANH_TABLE[idx_a];
    assign tb    = tsl_pkg::TANH_TABLE[idx_b];
    assign dabs  = (tb >= ta) ? (tb - ta) : (ta - tb);

    assign iround = {1'b0, iprod_reg} + (IP_W + 1)'(1 << (tsl_pkg::SEG_BITS - 1));
    assign adj    = iround[tsl_pkg::SEG_BITS +: tsl_pkg::TAB_W];

    always_ff @(posedge clk)
    begin
        if (cmd.interp_mul)
        begin
            a_reg     <= ta;
            up_reg    <= (tb >= ta);
            iprod_reg <= IP_W'(dabs) * IP_W'(frac);
        end
        if (cmd.interp_add)
        begin
            // Beyond the table range tanh is taken as exactly one.
            if (sat_reg)
            begin
                y_reg <= tsl_pkg::Y_W'(tsl_pkg::Q30_ONE);
            end
            else if (up_reg)
            begin
                y_reg <= a_reg + adj;
            end
            else
            begin
                y_reg <= a_reg - adj;
            end
        end
        if (cmd.scale_mul)
        begin
            s_reg <= S_W'(tsl_pkg::SPAN) * S_W'(y_reg);
        end
        if (cmd.pcm_mul)
        begin
            pprod_reg <= PROD_W'(outmag) * PROD_W'(tsl_pkg::PCM_SCALE);
        end
    end

    assign srnd   = {1'b0, s_reg} + (S_W + 1)'(tsl_pkg::Q30_HALF);
    assign outmag = limited_reg ? (MAG_W'(tsl_pkg::TS) + MAG_W'(srnd >> 30)) : mag_reg;

    // Round half to even, then clamp with the sign applied.
    assign q_trunc = pprod_reg[PROD_W-1:tsl_pkg::FRAC_BITS];
    assign q_rem   = pprod_reg[tsl_pkg::FRAC_BITS-1:0];
    assign q_inc   = (q_rem > tsl_pkg::FRAC_BITS'(1 << (tsl_pkg::FRAC_BITS - 1)))
                  || ((q_rem == tsl_pkg::FRAC_BITS'(1 << (tsl_pkg::FRAC_BITS - 1)))
                      && q_trunc[0]);
    assign q_rnd   = {1'b0, q_trunc} + QR_W'(q_inc);

    always_comb
    begin
        if (neg_reg && (q_rnd != '0))
        begin
            q_clamp = (q_rnd > QR_W'(tsl_pkg::PCM_NEG_MAG)) ? QR_W'(tsl_pkg::PCM_NEG_MAG)
                                                           : q_rnd;
            pcm_val = tsl_pkg::PCM_W'(QR_W'(1 << tsl_pkg::PCM_W) - q_clamp);
        end
        else
        begin
            q_clamp = (q_rnd > QR_W'(tsl_pkg::PCM_POS_MAX)) ? QR_W'(tsl_pkg::PCM_POS_MAX)
                                                           : q_rnd;
            pcm_val = q_clamp[tsl_pkg::PCM_W-1:0];
        end
    end

    assign peak_now    = (mag_reg > peak_reg) ? mag_reg : peak_reg;
    assign engaged_now = engaged_reg | limited_reg;

    // The statistics include the current sample and clear after the last one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg         <= '0;
            engaged_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                peak_reg    <= last_reg ? '0 : peak_now;
                engaged_reg <= last_reg ? 1'b0 : engaged_now;
            end
            if (cmd.load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pcm_reg         <= pcm_val;
            limited_now_reg <= limited_reg;
            peak_out_reg    <= peak_now;
            engaged_out_reg <= engaged_now;
            take_done_reg   <= last_reg;
        end
    end

    assign result_valid   = result_valid_reg;
    assign pcm            = pcm_reg;
    assign limited_now    = limited_now_reg;
    assign peak_so_far    = peak_out_reg;
    assign limited_so_far = engaged_out_reg;
    assign take_done      = take_done_reg;

endmodule

[src/tanh_soft_limiter_pcm16.sv]
// Tanh soft-knee limiter, Q1.22 samples in, 16-bit PCM out.
// Above the knee a sample steps through division, interpolation, scaling and the PCM
// multiply before the output load, at or below it through the PCM multiply alone; one
// sample is in flight at a time, as the multiply steps share the single datapath.
// Reset (rst_n, asynchronous) clears the sequencer, the output valid, the peak and the
// engaged flag; no clearing pass is needed.
module tanh_soft_limiter_pcm16 (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    output logic                               sample_ready,
    input  logic signed [tsl_pkg::SAMPLE_W-1:0] sample,
    input  logic                               last_of_take,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic signed [tsl_pkg::PCM_W-1:0]    pcm,
    output logic                               limited_now,
    output logic [tsl_pkg::SAMPLE_W-1:0]        peak_so_far,
    output logic                               limited_so_far,
    output logic                               take_done
);

    tsl_pkg::tsl_cmd_t    cmd;
    tsl_pkg::tsl_status_t status;

    tsl_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .status       (status),
        .cmd          (cmd)
    );

    tsl_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .sample         (sample),
        .last_of_take   (last_of_take),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .pcm            (pcm),
        .limited_now    (limited_now),
        .peak_so_far    (peak_so_far),
        .limited_so_far (limited_so_far),
        .take_done      (take_done)
    );

endmodule
